@@ design/kgpq_pkg.sv @@
// ----------------------------------------------------------------------------
// kgpq_pkg
// Shared types, constants and helpers for the keyframe-gated packet queue.
// ----------------------------------------------------------------------------
package kgpq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PTS_W    = 64;
  localparam int DUR_W    = 32;
  localparam int SIZE_W   = 24;
  localparam int HANDLE_W = 32;
  localparam int MS_W     = 32;
  localparam int CNT32_W  = 32;
  localparam int BYTES_W  = 64;
  localparam int HEALTH_W = 3;
  localparam int CFG_W    = 16;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 4;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // divide by 1000, four quotient bits per cycle
  localparam int DIV_K      = 1000;
  localparam int DIV_REM_W  = $clog2(DIV_K);
  localparam int DIV_STEP   = 4;
  localparam int DIV_ITERS  = MS_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);
  localparam int DIFF_W     = PTS_W + 1;
  localparam int SUM_W      = PTS_W + 2;
  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(DIV_K) << MS_W;

  typedef enum logic [1:0] {
    OP_PUSH       = 2'd0,
    OP_POP        = 2'd1,
    OP_CONNECT    = 2'd2,
    OP_DISCONNECT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MAX_BUFFER = 2'd0,
    REG_CONGESTED  = 2'd1,
    REG_WARNING    = 2'd2
  } reg_idx_t;

  localparam logic [HEALTH_W-1:0] HEALTH_DISCONNECTED = 3'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_RECOVERING   = 3'd1;
  localparam logic [HEALTH_W-1:0] HEALTH_CONGESTED    = 3'd2;
  localparam logic [HEALTH_W-1:0] HEALTH_WARNING      = 3'd3;
  localparam logic [HEALTH_W-1:0] HEALTH_HEALTHY      = 3'd4;

  localparam logic [CFG_W-1:0] MAX_BUFFER_RST = 16'd1500;
  localparam logic [CFG_W-1:0] CONGESTED_RST  = 16'd750;
  localparam logic [CFG_W-1:0] WARNING_RST    = 16'd250;

  typedef struct packed {
    op_t                 op;
    logic                kf_ok;
    logic [PTS_W-1:0]    pts;
    logic [DUR_W-1:0]    dur;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_buffer;
    logic [CFG_W-1:0] congested;
    logic [CFG_W-1:0] warning;
  } cfg_t;

  typedef struct packed {
    logic [PTS_W-1:0]    pts;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             start;
    logic [PTS_W-1:0] first_pts;
    logic [PTS_W-1:0] last_pts;
    logic [DUR_W-1:0] dur;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MS_W-1:0] q;
  } div_rsp_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [HEALTH_W-1:0] health_code(input logic running,
                                                       input logic recovering,
                                                       input logic [MS_W-1:0] q,
                                                       input cfg_t cfg);
    logic [HEALTH_W-1:0] h;
    if (!running) h = HEALTH_DISCONNECTED;
    else if (recovering) h = HEALTH_RECOVERING;
    else if (q > MS_W'(cfg.congested)) h = HEALTH_CONGESTED;
    else if (q > MS_W'(cfg.warning)) h = HEALTH_WARNING;
    else h = HEALTH_HEALTHY;
    return h;
  endfunction

endpackage

@@ design/keyframe_gated_packet_queue.sv @@
// ----------------------------------------------------------------------------
// keyframe_gated_packet_queue
// Packet descriptor queue with keyframe-gated recovery and backlog purge.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; a two-entry command
// queue lets up to two requests wait while one executes. Each request yields
// exactly one result, shown for one cycle with out_strobe; the receiver cannot
// stall it. Connect, disconnect, dropped or purging pushes and pops of an empty
// queue strobe straight from the idle state, a pop of the last packet after the
// head read, and an accepted push after the queued-time divide, which a pop of a
// non-last packet runs after the head reads (ending early when the queued time
// comes out zero or saturated). The descriptor store has one registered read
// port (head read, then new-head timestamp read), and the queued-time divide
// by 1000 produces four quotient bits per cycle. The result ports are only
// meaningful while out_strobe is high; counters and health may move earlier
// while a request executes. The store needs no clearing after reset.
module keyframe_gated_packet_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic                          in_is_video,
  input  logic                          in_is_keyframe,
  input  logic [kgpq_pkg::PTS_W-1:0]    in_pts,
  input  logic [kgpq_pkg::DUR_W-1:0]    in_pkt_duration,
  input  logic [kgpq_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [kgpq_pkg::HANDLE_W-1:0] in_handle,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kgpq_pkg::PADDR_W-1:0]  paddr,
  input  logic [kgpq_pkg::APB_W-1:0]    pwdata,
  output logic [kgpq_pkg::APB_W-1:0]    prdata,
  output logic                          pready,
  output logic                          out_strobe,
  output logic                          out_accepted,
  output logic                          out_keyframe_request,
  output logic                          out_valid,
  output logic [kgpq_pkg::HANDLE_W-1:0] out_handle,
  output logic [kgpq_pkg::PTS_W-1:0]    out_pts,
  output logic [kgpq_pkg::SIZE_W-1:0]   out_size,
  output logic [kgpq_pkg::MS_W-1:0]     out_queued_ms,
  output logic [kgpq_pkg::HEALTH_W-1:0] out_health,
  output logic [kgpq_pkg::CNT32_W-1:0]  out_dropped_total,
  output logic [kgpq_pkg::CNT32_W-1:0]  out_sent_total,
  output logic [kgpq_pkg::BYTES_W-1:0]  out_bytes_total
);
  import kgpq_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_buffer <= MAX_BUFFER_RST;
      cfg_r.congested  <= CONGESTED_RST;
      cfg_r.warning    <= WARNING_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_BUFFER: cfg_r.max_buffer <= pwdata[CFG_W-1:0];
        REG_CONGESTED:  cfg_r.congested  <= pwdata[CFG_W-1:0];
        REG_WARNING:    cfg_r.warning    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_BUFFER: prdata = APB_W'(cfg_r.max_buffer);
      REG_CONGESTED:  prdata = APB_W'(cfg_r.congested);
      REG_WARNING:    prdata = APB_W'(cfg_r.warning);
      default:        prdata = '0;
    endcase
  end

  kgpq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_is_video     (in_is_video),
    .in_is_keyframe  (in_is_keyframe),
    .in_pts          (in_pts),
    .in_pkt_duration (in_pkt_duration),
    .in_size_bytes   (in_size_bytes),
    .in_handle       (in_handle),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready)
  );

  kgpq_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_ready            (cmd_ready),
    .cfg                  (cfg_r),
    .out_strobe           (out_strobe),
    .out_accepted         (out_accepted),
    .out_keyframe_request (out_keyframe_request),
    .out_valid            (out_valid),
    .out_handle           (out_handle),
    .out_pts              (out_pts),
    .out_size             (out_size),
    .out_queued_ms        (out_queued_ms),
    .out_health           (out_health),
    .out_dropped_total    (out_dropped_total),
    .out_sent_total       (out_sent_total),
    .out_bytes_total      (out_bytes_total)
  );

endmodule

@@ design/kgpq_ram.sv @@
// ----------------------------------------------------------------------------
// kgpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kgpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/kgpq_div.sv @@
// ----------------------------------------------------------------------------
// kgpq_div
// Queued-time unit: (last pts + last duration - first pts) / 1000, clamped
// to zero below and saturated to 32 bits above, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module kgpq_div (
  input  logic               clk,
  input  logic               rst_n,
  input  kgpq_pkg::div_req_t req,
  output kgpq_pkg::div_rsp_t rsp
);
  import kgpq_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_SUM, D_CHK, D_ITER} dstate_t;

  dstate_t              state_r, state_nxt;
  logic [DIFF_W-1:0]    diff_r, diff_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [DUR_W-1:0]     dur_r, dur_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [MS_W-1:0]      work_r, work_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [MS_W-1:0]      q_r, q_nxt;

  logic [DIV_REM_W:0]   trial;
  logic [DIV_REM_W-1:0] rem_it;
  logic [MS_W-1:0]      work_it;

  always_comb begin
    rem_it  = rem_r;
    work_it = work_r;
    trial   = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial   = {rem_it, work_it[MS_W-1]};
      work_it = {work_it[MS_W-2:0], 1'b0};
      if (trial >= (DIV_REM_W + 1)'(DIV_K)) begin
        rem_it     = DIV_REM_W'(trial - (DIV_REM_W + 1)'(DIV_K));
        work_it[0] = 1'b1;
      end else begin
        rem_it = trial[DIV_REM_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    diff_nxt  = diff_r;
    sum_nxt   = sum_r;
    dur_nxt   = dur_r;
    rem_nxt   = rem_r;
    work_nxt  = work_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    q_nxt     = q_r;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          // offset-binary so the subtract is plain unsigned
          diff_nxt  = {1'b0, ~req.last_pts[PTS_W-1], req.last_pts[PTS_W-2:0]}
                    - {1'b0, ~req.first_pts[PTS_W-1], req.first_pts[PTS_W-2:0]};
          dur_nxt   = req.dur;
          state_nxt = D_SUM;
        end
      end
      D_SUM: begin
        sum_nxt   = {diff_r[DIFF_W-1], diff_r} + SUM_W'(dur_r);
        state_nxt = D_CHK;
      end
      D_CHK: begin
        if (sum_r[SUM_W-1] || sum_r == '0) begin
          q_nxt     = '0;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else if (sum_r >= SAT_LIMIT) begin
          q_nxt     = '1;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          rem_nxt   = sum_r[MS_W +: DIV_REM_W];
          work_nxt  = sum_r[MS_W-1:0];
          cnt_nxt   = '0;
          state_nxt = D_ITER;
        end
      end
      D_ITER: begin
        rem_nxt  = rem_it;
        work_nxt = work_it;
        cnt_nxt  = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
          q_nxt     = work_it;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    sum_r  <= sum_nxt;
    dur_r  <= dur_nxt;
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

@@ design/kgpq_front.sv @@
// ----------------------------------------------------------------------------
// kgpq_front
// Takes requests, decodes them and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module kgpq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic                          in_is_video,
  input  logic                          in_is_keyframe,
  input  logic [kgpq_pkg::PTS_W-1:0]    in_pts,
  input  logic [kgpq_pkg::DUR_W-1:0]    in_pkt_duration,
  input  logic [kgpq_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [kgpq_pkg::HANDLE_W-1:0] in_handle,
  output logic                          cmd_valid,
  output kgpq_pkg::cmd_t                cmd,
  input  logic                          cmd_ready
);
  import kgpq_pkg::*;

  cmd_t                  fifo_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  push, pop;
  cmd_t                  incoming;

  assign busy      = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo_r[rd_ptr_r];

  always_comb begin
    incoming.op     = op_t'(in_opcode);
    incoming.kf_ok  = in_is_video && in_is_keyframe;
    incoming.pts    = in_pts;
    incoming.dur    = in_pkt_duration;
    incoming.size   = in_size_bytes;
    incoming.handle = in_handle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      end
      cnt_r <= cnt_r + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

@@ design/kgpq_back.sv @@
// ----------------------------------------------------------------------------
// kgpq_back
// Executes queued requests: keyframe gating, purge, descriptor store, pop,
// counters and queued-time refresh.
// ----------------------------------------------------------------------------
module kgpq_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  kgpq_pkg::cmd_t                cmd,
  output logic                          cmd_ready,
  input  kgpq_pkg::cfg_t                cfg,
  output logic                          out_strobe,
  output logic                          out_accepted,
  output logic                          out_keyframe_request,
  output logic                          out_valid,
  output logic [kgpq_pkg::HANDLE_W-1:0] out_handle,
  output logic [kgpq_pkg::PTS_W-1:0]    out_pts,
  output logic [kgpq_pkg::SIZE_W-1:0]   out_size,
  output logic [kgpq_pkg::MS_W-1:0]     out_queued_ms,
  output logic [kgpq_pkg::HEALTH_W-1:0] out_health,
  output logic [kgpq_pkg::CNT32_W-1:0]  out_dropped_total,
  output logic [kgpq_pkg::CNT32_W-1:0]  out_sent_total,
  output logic [kgpq_pkg::BYTES_W-1:0]  out_bytes_total
);
  import kgpq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_POP, S_HEAD, S_DIV, S_WAIT} state_t;

  state_t               state_r, state_nxt;
  logic                 running_r, running_nxt;
  logic                 recovering_r, recovering_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT32_W-1:0]   dropped_r, dropped_nxt;
  logic [CNT32_W-1:0]   sent_r, sent_nxt;
  logic [BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [MS_W-1:0]      q_r, q_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [PTS_W-1:0]     head_pts_r, head_pts_nxt;
  logic [PTS_W-1:0]     tail_pts_r, tail_pts_nxt;
  logic [DUR_W-1:0]     tail_dur_r, tail_dur_nxt;
  logic                 acc_r, acc_nxt;
  logic                 kf_r, kf_nxt;
  logic                 valid_r, valid_nxt;
  logic [HANDLE_W-1:0]  o_handle_r, o_handle_nxt;
  logic [PTS_W-1:0]     o_pts_r, o_pts_nxt;
  logic [SIZE_W-1:0]    o_size_r, o_size_nxt;

  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               wr_entry, rd_entry;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign wr_entry  = '{pts: cmd.pts, size: cmd.size, handle: cmd.handle};
  assign rd_entry  = entry_t'(ram_rdata);
  assign cmd_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    recovering_nxt = recovering_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    dropped_nxt    = dropped_r;
    sent_nxt       = sent_r;
    bytes_nxt      = bytes_r;
    q_nxt          = q_r;
    strobe_nxt     = 1'b0;
    head_pts_nxt   = head_pts_r;
    tail_pts_nxt   = tail_pts_r;
    tail_dur_nxt   = tail_dur_r;
    acc_nxt        = acc_r;
    kf_nxt         = kf_r;
    valid_nxt      = valid_r;
    o_handle_nxt   = o_handle_r;
    o_pts_nxt      = o_pts_r;
    o_size_nxt     = o_size_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_r;
    div_req        = '{start: 1'b0, first_pts: head_pts_r, last_pts: tail_pts_r,
                       dur: tail_dur_r};
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          acc_nxt      = 1'b0;
          kf_nxt       = 1'b0;
          valid_nxt    = 1'b0;
          o_handle_nxt = '0;
          o_pts_nxt    = '0;
          o_size_nxt   = '0;
          strobe_nxt   = 1'b1;
          case (cmd.op)
            OP_PUSH: begin
              if (running_r) begin
                if (recovering_r && !cmd.kf_ok) begin
                  dropped_nxt = dropped_r + CNT32_W'(1);
                end else begin
                  recovering_nxt = 1'b0;
                  if (q_r >= MS_W'(cfg.max_buffer) ||
                      count_r == CNT_W'(QUEUE_DEPTH)) begin
                    // purge backlog, incoming packet discarded
                    dropped_nxt    = dropped_r + CNT32_W'(count_r);
                    head_nxt       = '0;
                    tail_nxt       = '0;
                    count_nxt      = '0;
                    q_nxt          = '0;
                    recovering_nxt = 1'b1;
                    kf_nxt         = 1'b1;
                  end else begin
                    ram_we       = 1'b1;
                    tail_nxt     = next_ptr(tail_r);
                    count_nxt    = count_r + CNT_W'(1);
                    tail_pts_nxt = cmd.pts;
                    tail_dur_nxt = cmd.dur;
                    if (count_r == '0) begin
                      head_pts_nxt = cmd.pts;
                    end
                    acc_nxt    = 1'b1;
                    strobe_nxt = 1'b0;
                    state_nxt  = S_DIV;
                  end
                end
              end
            end
            OP_POP: begin
              if (count_r != '0) begin
                ram_re     = 1'b1;
                strobe_nxt = 1'b0;
                state_nxt  = S_POP;
              end
            end
            OP_CONNECT: begin
              if (!running_r) begin
                running_nxt    = 1'b1;
                recovering_nxt = 1'b1;
                kf_nxt         = 1'b1;
              end
            end
            OP_DISCONNECT: begin
              if (running_r) begin
                running_nxt = 1'b0;
                head_nxt    = '0;
                tail_nxt    = '0;
                count_nxt   = '0;
                q_nxt       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        valid_nxt    = 1'b1;
        o_handle_nxt = rd_entry.handle;
        o_pts_nxt    = rd_entry.pts;
        o_size_nxt   = rd_entry.size;
        head_nxt     = next_ptr(head_r);
        count_nxt    = count_r - CNT_W'(1);
        sent_nxt     = sent_r + CNT32_W'(1);
        bytes_nxt    = bytes_r + BYTES_W'(rd_entry.size);
        if (count_r == CNT_W'(1)) begin
          q_nxt      = '0;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = next_ptr(head_r);
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_pts_nxt = rd_entry.pts;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          q_nxt      = div_rsp.q;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      running_r    <= 1'b0;
      recovering_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      dropped_r    <= '0;
      sent_r       <= '0;
      bytes_r      <= '0;
      q_r          <= '0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      recovering_r <= recovering_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      dropped_r    <= dropped_nxt;
      sent_r       <= sent_nxt;
      bytes_r      <= bytes_nxt;
      q_r          <= q_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_pts_r <= head_pts_nxt;
    tail_pts_r <= tail_pts_nxt;
    tail_dur_r <= tail_dur_nxt;
    acc_r      <= acc_nxt;
    kf_r       <= kf_nxt;
    valid_r    <= valid_nxt;
    o_handle_r <= o_handle_nxt;
    o_pts_r    <= o_pts_nxt;
    o_size_r   <= o_size_nxt;
  end

  kgpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kgpq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_strobe           = strobe_r;
  assign out_accepted         = acc_r;
  assign out_keyframe_request = kf_r;
  assign out_valid            = valid_r;
  assign out_handle           = o_handle_r;
  assign out_pts              = o_pts_r;
  assign out_size             = o_size_r;
  assign out_queued_ms        = q_r;
  assign out_health           = health_code(running_r, recovering_r, q_r, cfg);
  assign out_dropped_total    = dropped_r;
  assign out_sent_total       = sent_r;
  assign out_bytes_total      = bytes_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with unequal pointers");

  a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (count_r == '0))
    else $error("descriptors held while stopped");

  a_push_or_pop: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(acc_r && valid_r))
    else $error("result both accepted and popped");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (sent_r == $past(sent_r) + CNT32_W'(1)))
    else $error("pop did not count a sent packet");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyframe_gated_packet_queue. Requests go in through
// the start/busy port, registers through APB. A behavioral model of the queue
// predicts each result, and a monitor compares every strobed result, field by
// field, with the oldest prediction. Directed cases come first, then a fill
// and pointer-wrap run, then random traffic under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kgpq_pkg::*;

  localparam logic [1:0]       REG_SPARE = 2'd3;
  localparam logic [PTS_W-1:0] PTS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [PTS_W-1:0] PTS_MIN   = 64'h8000_0000_0000_0000;
  localparam int               US_PER_MS = 1000;
  localparam logic signed [PTS_W+2:0] MS_SAT = 67'sd4294967295;
  localparam int               RING_DEPTH = 16;
  localparam int               RING_W     = $clog2(RING_DEPTH);

  typedef struct packed {
    op_t                 op;
    logic                is_video;
    logic                is_keyframe;
    logic [PTS_W-1:0]    pts;
    logic [DUR_W-1:0]    dur;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } pkt_req_t;

  typedef struct packed {
    logic                accepted;
    logic                keyframe_request;
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [PTS_W-1:0]    pts;
    logic [SIZE_W-1:0]   size;
    logic [MS_W-1:0]     queued_ms;
    logic [HEALTH_W-1:0] health;
    logic [CNT32_W-1:0]  dropped;
    logic [CNT32_W-1:0]  sent;
    logic [BYTES_W-1:0]  bytes;
  } queue_status_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [1:0]          in_opcode       = OP_PUSH;
  logic                in_is_video     = 1'b0;
  logic                in_is_keyframe  = 1'b0;
  logic [PTS_W-1:0]    in_pts          = '0;
  logic [DUR_W-1:0]    in_pkt_duration = '0;
  logic [SIZE_W-1:0]   in_size_bytes   = '0;
  logic [HANDLE_W-1:0] in_handle       = '0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [APB_W-1:0]    pwdata          = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;
  logic                out_strobe;
  logic                out_accepted;
  logic                out_keyframe_request;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic [PTS_W-1:0]    out_pts;
  logic [SIZE_W-1:0]   out_size;
  logic [MS_W-1:0]     out_queued_ms;
  logic [HEALTH_W-1:0] out_health;
  logic [CNT32_W-1:0]  out_dropped_total;
  logic [CNT32_W-1:0]  out_sent_total;
  logic [BYTES_W-1:0]  out_bytes_total;

  keyframe_gated_packet_queue dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_is_video          (in_is_video),
    .in_is_keyframe       (in_is_keyframe),
    .in_pts               (in_pts),
    .in_pkt_duration      (in_pkt_duration),
    .in_size_bytes        (in_size_bytes),
    .in_handle            (in_handle),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .out_strobe           (out_strobe),
    .out_accepted         (out_accepted),
    .out_keyframe_request (out_keyframe_request),
    .out_valid            (out_valid),
    .out_handle           (out_handle),
    .out_pts              (out_pts),
    .out_size             (out_size),
    .out_queued_ms        (out_queued_ms),
    .out_health           (out_health),
    .out_dropped_total    (out_dropped_total),
    .out_sent_total       (out_sent_total),
    .out_bytes_total      (out_bytes_total)
  );

  // queue model state
  logic                run_q     = 1'b0;
  logic                recov_q   = 1'b0;
  logic [PTS_W-1:0]    pts_mem    [QUEUE_DEPTH];
  logic [DUR_W-1:0]    dur_mem    [QUEUE_DEPTH];
  logic [SIZE_W-1:0]   size_mem   [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] handle_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]    head_q    = '0;
  logic [PTR_W-1:0]    tail_q    = '0;
  int                  fill_q    = 0;
  logic [CNT32_W-1:0]  dropped_q = '0;
  logic [CNT32_W-1:0]  sent_q    = '0;
  logic [BYTES_W-1:0]  bytes_q   = '0;
  logic [CFG_W-1:0]    cfg_max   = MAX_BUFFER_RST;
  logic [CFG_W-1:0]    cfg_cong  = CONGESTED_RST;
  logic [CFG_W-1:0]    cfg_warn  = WARNING_RST;

  // predicted results in request order
  queue_status_t       status_ring [RING_DEPTH];
  int                  ring_wr        = 0;
  int                  ring_rd        = 0;
  int                  mismatch_count = 0;
  logic                idle_on        = 1'b1;
  logic [PTS_W-1:0]    stream_pts     = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [MS_W-1:0] backlog_ms();
    logic [PTR_W-1:0]         last;
    logic signed [PTS_W+2:0]  span;
    if (fill_q == 0) return '0;
    last = tail_q - 1'b1;
    span = $signed({{3{pts_mem[last][PTS_W-1]}}, pts_mem[last]})
         + $signed({35'd0, dur_mem[last]})
         - $signed({{3{pts_mem[head_q][PTS_W-1]}}, pts_mem[head_q]});
    if (span <= 0) return '0;
    span = span / US_PER_MS;
    if (span > MS_SAT) return '1;
    return span[MS_W-1:0];
  endfunction

  // QUEUE_DEPTH is a power of two, so the pointers wrap on their own
  function automatic queue_status_t step_queue(input pkt_req_t r);
    queue_status_t s;
    logic          pass;
    s = '0;
    case (r.op)
      OP_PUSH: begin
        if (run_q) begin
          pass = 1'b1;
          if (recov_q) begin
            if (r.is_video && r.is_keyframe) begin
              recov_q = 1'b0;
            end else begin
              dropped_q = dropped_q + 1'b1;
              pass = 1'b0;
            end
          end
          if (pass) begin
            if (backlog_ms() >= MS_W'(cfg_max) || fill_q >= QUEUE_DEPTH) begin
              dropped_q = dropped_q + CNT32_W'(fill_q);
              head_q = '0;
              tail_q = '0;
              fill_q = 0;
              recov_q = 1'b1;
              s.keyframe_request = 1'b1;
            end else begin
              pts_mem[tail_q] = r.pts;
              dur_mem[tail_q] = r.dur;
              size_mem[tail_q] = r.size;
              handle_mem[tail_q] = r.handle;
              tail_q = tail_q + 1'b1;
              fill_q++;
              s.accepted = 1'b1;
            end
          end
        end
      end
      OP_POP: begin
        if (fill_q != 0) begin
          s.valid = 1'b1;
          s.handle = handle_mem[head_q];
          s.pts = pts_mem[head_q];
          s.size = size_mem[head_q];
          head_q = head_q + 1'b1;
          fill_q--;
          sent_q = sent_q + 1'b1;
          bytes_q = bytes_q + BYTES_W'(s.size);
        end
      end
      OP_CONNECT: begin
        if (!run_q) begin
          run_q = 1'b1;
          recov_q = 1'b1;
          s.keyframe_request = 1'b1;
        end
      end
      default: begin
        if (run_q) begin
          run_q = 1'b0;
          head_q = '0;
          tail_q = '0;
          fill_q = 0;
        end
      end
    endcase
    s.queued_ms = backlog_ms();
    if (!run_q) s.health = HEALTH_DISCONNECTED;
    else if (recov_q) s.health = HEALTH_RECOVERING;
    else if (s.queued_ms > MS_W'(cfg_cong)) s.health = HEALTH_CONGESTED;
    else if (s.queued_ms > MS_W'(cfg_warn)) s.health = HEALTH_WARNING;
    else s.health = HEALTH_HEALTHY;
    s.dropped = dropped_q;
    s.sent = sent_q;
    s.bytes = bytes_q;
    return s;
  endfunction

  function automatic pkt_req_t make_req(input op_t op, input logic vid, input logic key,
                                        input logic [PTS_W-1:0] pts,
                                        input logic [DUR_W-1:0] dur,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [HANDLE_W-1:0] handle);
    pkt_req_t r;
    r.op = op;
    r.is_video = vid;
    r.is_keyframe = key;
    r.pts = pts;
    r.dur = dur;
    r.size = size;
    r.handle = handle;
    return r;
  endfunction

  function automatic pkt_req_t random_req();
    pkt_req_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (!run_q && $urandom_range(0, 1) == 1) r.op = OP_CONNECT;
    else if (pick < 55) r.op = OP_PUSH;
    else if (pick < 85) r.op = OP_POP;
    else if (pick < 92) r.op = OP_CONNECT;
    else r.op = OP_DISCONNECT;
    r.is_video = ($urandom_range(0, 9) < 7);
    r.is_keyframe = recov_q ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0: r.pts = {$urandom, $urandom};
      1: r.pts = stream_pts - PTS_W'($urandom_range(0, 200000));
      default: begin
        stream_pts = stream_pts + PTS_W'($urandom_range(0, 80000));
        r.pts = stream_pts;
      end
    endcase
    r.dur = ($urandom_range(0, 6) == 0) ? $urandom : DUR_W'($urandom_range(0, 40000));
    r.size = SIZE_W'($urandom);
    r.handle = $urandom;
    return r;
  endfunction

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(input pkt_req_t r);
    start <= 1'b1;
    in_opcode <= r.op;
    in_is_video <= r.is_video;
    in_is_keyframe <= r.is_keyframe;
    in_pts <= r.pts;
    in_pkt_duration <= r.dur;
    in_size_bytes <= r.size;
    in_handle <= r.handle;
    do @(posedge clk); while (busy);
    status_ring[RING_W'(ring_wr)] = step_queue(r);
    ring_wr++;
    if (idle_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
  endtask

  task automatic settle_queue();
    start <= 1'b0;
    do @(posedge clk); while (ring_wr != ring_rd || busy);
  endtask

  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [APB_W-1:0] wdata, output logic [APB_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic cfg_write_check(input logic [1:0] idx, input logic [CFG_W-1:0] v);
    logic [APB_W-1:0] rd;
    apb_transfer(1'b1, idx, {16'($urandom), v}, rd);
    case (idx)
      REG_MAX_BUFFER: cfg_max = v;
      REG_CONGESTED:  cfg_cong = v;
      REG_WARNING:    cfg_warn = v;
      default: ;
    endcase
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== APB_W'(v)) report_mismatch("register readback", 64'(rd), 64'(v));
  endtask

  // only while idle; the write to the unmapped address must change nothing
  task automatic program_regs(input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] cg,
                              input logic [CFG_W-1:0] wn);
    logic [APB_W-1:0] rd;
    settle_queue();
    cfg_write_check(REG_MAX_BUFFER, mx);
    cfg_write_check(REG_CONGESTED, cg);
    cfg_write_check(REG_WARNING, wn);
    apb_transfer(1'b1, REG_SPARE, $urandom, rd);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, PTS_MAX, '1, '1, '1));
    send_request(make_req(OP_POP, 1'b0, 1'b0, '0, '0, '0, '0));
    send_request(make_req(OP_DISCONNECT, 1'b0, 1'b0, '0, '0, '0, '0));
    send_request(make_req(OP_CONNECT, 1'b0, 1'b0, '0, '0, '0, '0));
    send_request(make_req(OP_CONNECT, 1'b1, 1'b1, '1, '1, '1, '1));
    // recovery gate: only a video keyframe gets through
    send_request(make_req(OP_PUSH, 1'b0, 1'b0, 64'd10, 32'd10, 24'd1, 32'd1));
    send_request(make_req(OP_PUSH, 1'b1, 1'b0, 64'd20, 32'd10, 24'd2, 32'd2));
    send_request(make_req(OP_PUSH, 1'b0, 1'b1, 64'd30, 32'd10, 24'd3, 32'd3));
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, 64'd0, 32'd1000, 24'd0, 32'd0));
    send_request(make_req(OP_PUSH, 1'b1, 1'b0, 64'd300000, 32'd200, 24'h00ABCD, 32'h1234));
    send_request(make_req(OP_PUSH, 1'b0, 1'b0, 64'd1000000, 32'd500000, '1, '1));
    // backlog at the limit: purge
    send_request(make_req(OP_PUSH, 1'b1, 1'b0, 64'd1100000, 32'd10, 24'd5, 32'd5));
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, PTS_MIN, 32'd0, '1, 32'hFFFF_0000));
    send_request(make_req(OP_PUSH, 1'b1, 1'b0, PTS_MAX, '1, 24'h800000, 32'h0000_FFFF));
    send_request(make_req(OP_POP, 1'b1, 1'b1, '1, '1, '1, '1));
    send_request(make_req(OP_POP, 1'b0, 1'b0, '0, '0, '0, '0));
    send_request(make_req(OP_POP, 1'b0, 1'b0, '0, '0, '0, '0));
    // last pts behind first: negative span
    send_request(make_req(OP_PUSH, 1'b0, 1'b0, 64'd1000000, 32'd10, 24'd7, 32'd7));
    send_request(make_req(OP_PUSH, 1'b1, 1'b0, 64'd0, 32'd5000, 24'd8, 32'd8));
    send_request(make_req(OP_DISCONNECT, 1'b1, 1'b1, '1, '1, '1, '1));
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, 64'd0, 32'd0, 24'd9, 32'd9));
    send_request(make_req(OP_CONNECT, 1'b0, 1'b0, '0, '0, '0, '0));
    program_regs(16'd0, 16'hFFFF, 16'd0);
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, 64'd0, 32'd0, 24'd10, 32'd10));
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, 64'd5, 32'd0, 24'd11, 32'd11));
  endtask

  task automatic test_queue_full_wrap();
    logic [PTS_W-1:0] base;
    base = {2'b00, 30'($urandom), $urandom};
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(make_req(OP_DISCONNECT, 1'b0, 1'b0, '0, '0, '0, '0));
    send_request(make_req(OP_CONNECT, 1'b0, 1'b0, '0, '0, '0, '0));
    send_request(make_req(OP_PUSH, 1'b1, 1'b1, base, 32'd0, 24'($urandom), $urandom));
    for (int k = 1; k < QUEUE_DEPTH; k++)
      send_request(make_req(OP_PUSH, 1'($urandom), 1'($urandom), base + PTS_W'(k),
                            DUR_W'($urandom_range(0, 100)), 24'($urandom), $urandom));
    for (int k = 0; k < 16; k++)
      send_request(make_req(OP_POP, 1'($urandom), 1'($urandom), {$urandom, $urandom},
                            $urandom, 24'($urandom), $urandom));
    for (int k = 0; k < 16; k++)
      send_request(make_req(OP_PUSH, 1'b1, 1'($urandom), base + PTS_W'(QUEUE_DEPTH + k),
                            DUR_W'($urandom_range(0, 100)), 24'($urandom), $urandom));
    // full queue: purge
    send_request(make_req(OP_PUSH, 1'b1, 1'b0, base + PTS_W'(2 * QUEUE_DEPTH), 32'd0,
                          24'($urandom), $urandom));
    send_request(make_req(OP_POP, 1'b0, 1'b0, '0, '0, '0, '0));
  endtask

  task automatic test_random_traffic();
    pkt_req_t r;
    int       counted;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(MAX_BUFFER_RST, CONGESTED_RST, WARNING_RST);
        1: program_regs(16'd0, 16'd0, 16'd0);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_regs(16'($urandom_range(300, 3000)), 16'($urandom_range(100, 1500)),
                        16'($urandom_range(0, 800)));
        4: program_regs(16'hFFFF, 16'd0, 16'd0);
        default: program_regs(16'($urandom), 16'($urandom_range(0, 2000)),
                              16'($urandom_range(0, 1000)));
      endcase
      idle_on = (ph != 5);
      stream_pts = {{3{1'($urandom)}}, 29'($urandom), $urandom};
      if (!run_q)
        send_request(make_req(OP_CONNECT, 1'b0, 1'b0, '0, '0, '0, '0));
      send_request(make_req(OP_PUSH, 1'b1, 1'b1, stream_pts, DUR_W'($urandom_range(0, 40000)),
                            24'($urandom), $urandom));
      counted = 0;
      while (counted < 55) begin
        r = random_req();
        if (run_q || r.op == OP_CONNECT) counted++;
        send_request(r);
        if (ph == 3 && counted == 25) settle_queue();
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    queue_status_t want;
    if (rst_n && out_strobe) begin
      if (ring_wr == ring_rd) begin
        report_mismatch("result with no pending request", '0, '0);
      end else begin
        want = status_ring[RING_W'(ring_rd)];
        ring_rd++;
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", 64'(out_accepted), 64'(want.accepted));
        if (out_keyframe_request !== want.keyframe_request)
          report_mismatch("keyframe_request", 64'(out_keyframe_request),
                          64'(want.keyframe_request));
        if (out_valid !== want.valid)
          report_mismatch("valid", 64'(out_valid), 64'(want.valid));
        if (out_handle !== want.handle)
          report_mismatch("handle", 64'(out_handle), 64'(want.handle));
        if (out_pts !== want.pts)
          report_mismatch("pts", out_pts, want.pts);
        if (out_size !== want.size)
          report_mismatch("size", 64'(out_size), 64'(want.size));
        if (out_queued_ms !== want.queued_ms)
          report_mismatch("queued_ms", 64'(out_queued_ms), 64'(want.queued_ms));
        if (out_health !== want.health)
          report_mismatch("health", 64'(out_health), 64'(want.health));
        if (out_dropped_total !== want.dropped)
          report_mismatch("dropped_total", 64'(out_dropped_total), 64'(want.dropped));
        if (out_sent_total !== want.sent)
          report_mismatch("sent_total", 64'(out_sent_total), 64'(want.sent));
        if (out_bytes_total !== want.bytes)
          report_mismatch("bytes_total", out_bytes_total, want.bytes);
      end
    end
  end

  initial begin : main_flow
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_queue_full_wrap();
    test_random_traffic();
    settle_queue();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
